>>> rtl/i2a_pkg.sv
// ----------------------------------------------------------------------------
// i2a_pkg: shared types and constants for integer_to_ascii_radix
// Radix limits, default widths, back-end state encoding and digit-to-ASCII
// mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package i2a_pkg;

  // default width of the converted integer
  localparam int VALUE_WIDTH_DEF = 32;
  // depth of the word queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;
  // quotient bits resolved per divider cycle
  localparam int DIV_STEP        = 8;

  // radix register
  localparam int             BASE_W     = 6;
  localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
  localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;

  // character codes
  localparam logic [7:0] CHAR_MINUS  = 8'h2d;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [5:0] DIGIT_MAX   = 6'd35;
  localparam logic [5:0] DIGIT_TEN   = 6'd10;

  // back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_FETCH,
    BK_OUT
  } bk_state_e;

  // digit value to '0'-'9' or 'a'-'z', values above 35 clamp to 'z'
  function automatic logic [7:0] digit_to_ascii(input logic [5:0] digit);
    logic [5:0] d;
    logic [7:0] c;
    d = (digit > DIGIT_MAX) ? DIGIT_MAX : digit;
    if (d < DIGIT_TEN) begin
      c = CHAR_ZERO + {2'b00, d};
    end else begin
      c = CHAR_LOWER_A + {2'b00, d - DIGIT_TEN};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/integer_to_ascii_radix.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_radix: signed integer to ASCII text in a chosen radix
//
//   channel   direction  ports                            handshake
//   input     in         start, busy, value_i             start && !busy
//   result    out        char_valid_o, character_o,       one-cycle strobe
//                        last_char_o
//   radix     in         number_base_we_i, number_base_i  write enable
//
// Each digit is one division by the radix: the shared restoring divider
// resolves 8 quotient bits per cycle. Characters stream out one per cycle
// after the last division.
// The input stage and a two-word queue take new numbers while the engine
// works; busy is high the cycle after each accepted word and stays high
// while the queue is full. Results cannot be held off.
// Reset clears control state and sets the radix to ten; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_radix #(
  parameter int VALUE_WIDTH = i2a_pkg::VALUE_WIDTH_DEF,
  parameter int QUEUE_DEPTH = i2a_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [VALUE_WIDTH-1:0]     value_i,
  input  wire logic                       number_base_we_i,
  input  wire logic [i2a_pkg::BASE_W-1:0] number_base_i,
  output logic                            char_valid_o,
  output logic [7:0]                      character_o,
  output logic                            last_char_o
);

  import i2a_pkg::*;

  logic [BASE_W-1:0]    number_base_q;
  logic [BASE_W-1:0]    base_eff;
  logic                 push;
  logic [VALUE_WIDTH:0] push_data;
  logic                 full;
  logic                 pop;
  logic                 q_valid;
  logic [VALUE_WIDTH:0] q_data;

  // radix register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_base_q <= BASE_RESET;
    end else if (number_base_we_i) begin
      number_base_q <= number_base_i;
    end
  end

  // saturate the radix into two to thirty-six
  always_comb begin
    if (number_base_q < BASE_MIN) begin
      base_eff = BASE_MIN;
    end else if (number_base_q > BASE_MAX) begin
      base_eff = BASE_MAX;
    end else begin
      base_eff = number_base_q;
    end
  end

  i2a_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .value_i     (value_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  i2a_queue #(
    .WIDTH (VALUE_WIDTH + 1),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  i2a_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .base_i       (base_eff),
    .q_valid_i    (q_valid),
    .q_data_i     (q_data),
    .q_pop_o      (pop),
    .char_valid_o (char_valid_o),
    .character_o  (character_o),
    .last_char_o  (last_char_o)
  );

endmodule

`default_nettype wire

>>> rtl/i2a_front.sv
// ----------------------------------------------------------------------------
// i2a_front: input stage
// Takes one integer per start, splits it into sign and magnitude and hands
// the word to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module i2a_front #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [VALUE_WIDTH-1:0] value_i,
  output logic                        push_o,
  output logic [VALUE_WIDTH:0]        push_data_o,
  input  wire logic                   full_i
);

  logic                   valid_q, valid_d;
  logic                   neg_q, neg_d;
  logic [VALUE_WIDTH-1:0] mag_q, mag_d;
  logic                   accept;

  // holding register is busy until its word moves into the queue
  assign busy   = valid_q;
  assign accept = start && !valid_q;
  assign push_o = valid_q && !full_i;
  assign push_data_o = {neg_q, mag_q};

  // sign and magnitude; the most negative value maps onto itself unsigned
  always_comb begin
    valid_d = valid_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    if (push_o) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      valid_d = 1'b1;
      neg_d   = value_i[VALUE_WIDTH-1];
      mag_d   = value_i[VALUE_WIDTH-1] ? (~value_i + 1'b1) : value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    mag_q <= mag_d;
  end

endmodule

`default_nettype wire

>>> rtl/i2a_queue.sv
// ----------------------------------------------------------------------------
// i2a_queue: small word queue
// First-in first-out buffer that decouples the input stage from the
// conversion engine.
// ----------------------------------------------------------------------------
`default_nettype none

module i2a_queue #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      pop_data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;

  assign full_o     = (count_q == CW'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = entry_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/i2a_back.sv
// ----------------------------------------------------------------------------
// i2a_back: conversion engine
// Repeated division by the radix, several quotient bits a cycle, digits
// kept in a small store, then read out most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

module i2a_back #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [i2a_pkg::BASE_W-1:0]   base_i,
  input  wire logic                         q_valid_i,
  input  wire logic [VALUE_WIDTH:0]         q_data_i,
  output logic                              q_pop_o,
  output logic                              char_valid_o,
  output logic [7:0]                        character_o,
  output logic                              last_char_o
);

  import i2a_pkg::*;

  localparam int NCHUNK = (VALUE_WIDTH + DIV_STEP - 1) / DIV_STEP;
  localparam int DW     = NCHUNK * DIV_STEP;
  localparam int KW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int AW     = $clog2(VALUE_WIDTH);

  bk_state_e         state_q, state_d;
  logic [DW-1:0]     dvd_q;
  logic [BASE_W-1:0] rem_q;
  logic [KW-1:0]     chunk_q;
  logic [AW-1:0]     n_q;
  logic [AW-1:0]     ptr_q;
  logic              neg_q;

  logic [BASE_W-1:0] store_q [VALUE_WIDTH];
  logic [BASE_W-1:0] rd_data_q;
  logic [AW-1:0]     rd_addr;

  logic [DIV_STEP-1:0] chunk_bits;
  logic [DIV_STEP-1:0] qbits;
  logic [BASE_W-1:0]   rem_w;
  logic [BASE_W:0]     trial;
  logic [DW-1:0]       quot_next;
  logic                chunk_last;
  logic                quot_zero;

  // one chunk of restoring division, remainder stays below the radix
  always_comb begin
    chunk_bits = dvd_q[DW-1 -: DIV_STEP];
    rem_w      = rem_q;
    qbits      = '0;
    trial      = '0;
    for (int i = DIV_STEP - 1; i >= 0; i--) begin
      trial = {rem_w, chunk_bits[i]};
      if (trial >= {1'b0, base_i}) begin
        trial    = trial - {1'b0, base_i};
        qbits[i] = 1'b1;
      end
      rem_w = trial[BASE_W-1:0];
    end
    quot_next  = (dvd_q << DIV_STEP) | DW'(qbits);
    chunk_last = (chunk_q == KW'(NCHUNK - 1));
    quot_zero  = (quot_next == '0);
  end

  // sequencer: next state and character outputs
  always_comb begin
    state_d      = state_q;
    q_pop_o      = 1'b0;
    char_valid_o = 1'b0;
    character_o  = digit_to_ascii(rd_data_q);
    last_char_o  = 1'b0;
    rd_addr      = ptr_q;
    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          state_d = BK_DIV;
        end
      end
      BK_DIV: begin
        if (chunk_last && quot_zero) begin
          state_d = BK_FETCH;
        end
      end
      BK_FETCH: begin
        // sign goes out while the top digit is read
        char_valid_o = neg_q;
        character_o  = CHAR_MINUS;
        state_d      = BK_OUT;
      end
      BK_OUT: begin
        char_valid_o = 1'b1;
        last_char_o  = (ptr_q == '0);
        rd_addr      = ptr_q - 1'b1;
        if (ptr_q == '0) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // division and readout counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= '0;
      chunk_q <= '0;
      n_q     <= '0;
      ptr_q   <= '0;
      neg_q   <= 1'b0;
    end else begin
      case (state_q)
        BK_IDLE: begin
          if (q_valid_i) begin
            neg_q   <= q_data_i[VALUE_WIDTH];
            rem_q   <= '0;
            chunk_q <= '0;
            n_q     <= '0;
          end
        end
        BK_DIV: begin
          if (chunk_last) begin
            rem_q   <= '0;
            chunk_q <= '0;
            if (quot_zero) begin
              ptr_q <= n_q;
            end else begin
              n_q <= n_q + 1'b1;
            end
          end else begin
            rem_q   <= rem_w;
            chunk_q <= chunk_q + 1'b1;
          end
        end
        BK_OUT: begin
          if (ptr_q != '0) begin
            ptr_q <= ptr_q - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // dividend shift register, ends each pass holding the quotient
  always_ff @(posedge clk_i) begin
    if (state_q == BK_IDLE) begin
      dvd_q <= DW'(q_data_i[VALUE_WIDTH-1:0]);
    end else if (state_q == BK_DIV) begin
      dvd_q <= quot_next;
    end
  end

  // digit store, least significant digit at index zero
  always_ff @(posedge clk_i) begin
    if (state_q == BK_DIV && chunk_last) begin
      store_q[n_q] <= rem_w;
    end
    rd_data_q <= store_q[rd_addr];
  end

  // a character only leaves in the sign or readout states
  a_strobe_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_valid_o |-> (state_q == BK_OUT) || (state_q == BK_FETCH && neg_q))
    else $error("character strobe outside readout");

  // the final flag marks the least significant digit only
  a_last_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (char_valid_o && last_char_o) |-> (state_q == BK_OUT && ptr_q == '0))
    else $error("last flag on a non-final digit");

  // after the final character the engine is free for the next word
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (char_valid_o && last_char_o) |=> (state_q == BK_IDLE))
    else $error("engine not idle after final character");

  // partial remainder never reaches the radix
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DIV) |-> (rem_q < base_i))
    else $error("partial remainder out of range");

  // a word is taken from the queue only when the engine is idle
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (state_q == BK_DIV && n_q == '0 && chunk_q == '0))
    else $error("queue pop outside idle");

endmodule

`default_nettype wire
